/* rtl/sats_pkg.sv */
// ----------------------------------------------------------------------------
// sats_pkg: shared types and constants of the sector aligned transfer splitter
// Holds the request, command, configuration and plan records, the status
// and register index codes, and the fixed sizing constants.
// ----------------------------------------------------------------------------
package sats_pkg;

  // Sizing constants
  localparam int unsigned BOUNCE_BYTES = 4096;
  localparam int unsigned MAX_PIECES   = 64;
  localparam int unsigned PIECE_W      = $clog2(MAX_PIECES + 1);
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned SS_W         = 13;
  localparam int unsigned BOUNCE_W     = $clog2(BOUNCE_BYTES + 1);
  localparam int unsigned CMP_W        = (BOUNCE_W > SS_W) ? BOUNCE_W : SS_W;
  localparam int unsigned PROD_W       = 32 + PIECE_W;
  localparam int unsigned CFG_IDX_W    = 2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRANSFER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [63:0] start_offset;
    logic [31:0] byte_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        via_bounce;
    logic        is_write;
    logic [63:0] device_offset;
    logic [31:0] device_bytes;
    logic [31:0] buffer_offset;
    logic [11:0] bounce_start;
    logic [31:0] copy_bytes;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [SS_W-1:0] sector_bytes;
    logic [31:0]     max_transfer;
    logic [63:0]     capacity;
  } cfg_t;

  // One classified request, handed from the front to the back
  typedef struct packed {
    logic [1:0]      status;
    logic            mode;
    logic [SS_W-1:0] sector_bytes;
    logic [SS_W-1:0] sec_off;
    logic            has_head;
    logic [SS_W-1:0] head_cnt;
    logic [63:0]     head_off;
    logic [63:0]     mid_off;
    logic [31:0]     direct_len;
    logic [31:0]     chunk;
    logic [SS_W-1:0] tail_cnt;
  } plan_t;

endpackage

/* rtl/sats_stream_if.sv */
// ----------------------------------------------------------------------------
// sats_stream_if: valid/ready channel
// Carries one payload record per transfer; the source drives valid and data,
// the sink drives ready.
// ----------------------------------------------------------------------------
interface sats_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/sector_aligned_transfer_splitter.sv */
// ----------------------------------------------------------------------------
// sector_aligned_transfer_splitter: byte-range request to device commands
// Splits a read or write byte range into head and tail bounce-sector
// commands and capped whole-sector direct commands.
//
//   channel  dir  transfer                       payload
//   req_i    in   one request                    mode, start_offset, byte_length
//   cmd_o    out  one command or error result    status ... last
//   cfg      in   one register write (cfg_we_i)  cfg_idx_i, cfg_data_i
//
// A valid request passes the front in order: accept, check, radix-4
// remainders (32 steps, then a look to see them finish), plan, size, push.
// The back loads a plan, then issues one command per cycle while cmd_o is
// not stalled; the front works on the next request while the back walks.
// Async active-low reset empties the queue; 512-byte sector, no cap, no capacity.
// A stalled cmd_o holds the back; the queue then fills and holds the front.
// ----------------------------------------------------------------------------
module sector_aligned_transfer_splitter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sats_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                    cfg_data_i,
  sats_stream_if.sink                    req_i,
  sats_stream_if.source                  cmd_o
);
  import sats_pkg::*;

  cfg_t  cfg_q;
  plan_t q_wdata;
  plan_t q_rdata;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  logic  req_ready;
  logic  cmd_valid;
  cmd_t  cmd_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sector_bytes <= SS_W'(512);
      cfg_q.max_transfer <= 32'd0;
      cfg_q.capacity     <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SECTOR_BYTES: cfg_q.sector_bytes <= cfg_data_i[SS_W-1:0];
        CFG_MAX_TRANSFER: cfg_q.max_transfer <= cfg_data_i[31:0];
        CFG_CAPACITY:     cfg_q.capacity     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sats_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .req_i       (req_i.data),
    .push_o      (q_push),
    .full_i      (q_full),
    .plan_o      (q_wdata)
  );

  sats_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  sats_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .plan_i      (q_rdata),
    .pop_o       (q_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_o.ready),
    .cmd_o       (cmd_data)
  );

  assign req_i.ready = req_ready;
  assign cmd_o.valid = cmd_valid;
  assign cmd_o.data  = cmd_data;

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("plan pushed while queue full");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && (cmd_data.status != STATUS_OK)) |-> cmd_data.last)
    else $error("error result without last");

  a_bounce_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && (cmd_data.status == STATUS_OK) && cmd_data.via_bounce) |->
    ((cmd_data.copy_bytes != 32'd0) && (cmd_data.copy_bytes <= cmd_data.device_bytes)))
    else $error("bounce copy outside the sector");

  a_direct_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && (cmd_data.status == STATUS_OK) && !cmd_data.via_bounce) |->
    ((cmd_data.copy_bytes == cmd_data.device_bytes) && (cmd_data.bounce_start == 12'd0)))
    else $error("direct command not whole");
`endif

endmodule

/* rtl/sats_rem.sv */
// ----------------------------------------------------------------------------
// sats_rem: radix-4 remainder unit
// Reduces a 64-bit dividend modulo a 13-bit divisor, two dividend bits per
// cycle over 32 steps after a start pulse.
// ----------------------------------------------------------------------------
module sats_rem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sats_pkg::SS_W-1:0] divisor_i,
  input  logic [63:0]               dividend_i,
  output logic                      busy_o,
  output logic [sats_pkg::SS_W-1:0] rem_o
);
  import sats_pkg::*;

  localparam int unsigned STEPS = 32;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [63:0]      dvd_q;
  logic [SS_W-1:0]  dsr_q;
  logic [SS_W-1:0]  r_q;

  // One restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [SS_W-1:0] rem_step(logic [SS_W-1:0] r, logic b,
                                               logic [SS_W-1:0] d);
    logic [SS_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[SS_W-1:0];
  endfunction

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Shift the dividend through two steps per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      r_q   <= '0;
    end else if (busy_q) begin
      r_q   <= rem_step(rem_step(r_q, dvd_q[63], dsr_q), dvd_q[62], dsr_q);
      dvd_q <= {dvd_q[61:0], 2'b00};
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = r_q;

endmodule

/* rtl/sats_front.sv */
// ----------------------------------------------------------------------------
// sats_front: request intake and classification
// Checks a request, takes the start offset, length and transfer cap modulo
// the sector size, sizes the head, direct and tail pieces, checks the piece
// budget and pushes one plan into the queue.
// ----------------------------------------------------------------------------
module sats_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sats_pkg::cfg_t  cfg_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  sats_pkg::req_t  req_i,
  output logic            push_o,
  input  logic            full_i,
  output sats_pkg::plan_t plan_o
);
  import sats_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_CHECK = 3'd1;
  localparam logic [2:0] F_DIV   = 3'd2;
  localparam logic [2:0] F_PLAN  = 3'd3;
  localparam logic [2:0] F_SIZE  = 3'd4;
  localparam logic [2:0] F_PUSH  = 3'd5;

  logic [2:0] state_q, state_d;

  req_t              req_q;
  logic              invalid_q;
  logic [SS_W-1:0]   within_q;
  logic              has_head_q;
  logic [SS_W-1:0]   head_cnt_q;
  logic [SS_W-1:0]   tail_q;
  logic [63:0]       head_off_q;
  logic [31:0]       chunk_q;
  logic [PIECE_W-1:0] k_q;
  logic [31:0]       direct_len_q;
  logic [63:0]       mid_off_q;
  logic [PROD_W-1:0] prod_q;

  logic [SS_W-1:0] ss;
  logic [64:0]     end_sum;
  logic            bad;
  logic            rem_start;
  logic            rem_busy;
  logic [SS_W-1:0] sec_off;
  logic [SS_W-1:0] len_mod;
  logic [SS_W-1:0] mt_mod;
  logic [SS_W-1:0] gap;
  logic            len_small;
  logic            has_head;
  logic            head_all;
  logic [SS_W-1:0] head_cnt;
  logic [SS_W:0]   tail_sum;
  logic [SS_W-1:0] tail_red;
  logic [SS_W-1:0] tail;
  logic [31:0]     chunk;
  logic [PIECE_W-1:0] k;
  logic            too_many;
  logic [1:0]      status;

  assign ss = cfg_i.sector_bytes;

  // Screen the request
  assign end_sum = {1'b0, req_q.start_offset} + 65'(req_q.byte_length);
  assign bad = (req_q.byte_length == 32'd0) || (ss == '0) ||
               (CMP_W'(ss) > CMP_W'(BOUNCE_BYTES)) || end_sum[64] ||
               (end_sum[63:0] > cfg_i.capacity);
  assign rem_start = (state_q == F_CHECK) && !bad;

  // Remainders of offset, length and transfer cap, run side by side
  sats_rem u_rem_off (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .divisor_i  (ss),
    .dividend_i (req_q.start_offset),
    .busy_o     (rem_busy),
    .rem_o      (sec_off)
  );

  sats_rem u_rem_len (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .divisor_i  (ss),
    .dividend_i ({32'd0, req_q.byte_length}),
    .busy_o     (),
    .rem_o      (len_mod)
  );

  sats_rem u_rem_mt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .divisor_i  (ss),
    .dividend_i ({32'd0, cfg_i.max_transfer}),
    .busy_o     (),
    .rem_o      (mt_mod)
  );

  // Size the head and tail pieces and the direct chunk
  always_comb begin
    gap       = ss - sec_off;
    len_small = req_q.byte_length < 32'(ss);
    has_head  = (sec_off != '0) || len_small;
    head_all  = (sec_off != '0) ? (req_q.byte_length <= 32'(gap)) : len_small;
    if (!has_head) begin
      head_cnt = '0;
    end else if ((sec_off != '0) && !head_all) begin
      head_cnt = gap;
    end else begin
      head_cnt = req_q.byte_length[SS_W-1:0];
    end
    tail_sum = {1'b0, len_mod} + {1'b0, sec_off};
    if (tail_sum >= {1'b0, ss}) begin
      tail_red = SS_W'(tail_sum - {1'b0, ss});
    end else begin
      tail_red = tail_sum[SS_W-1:0];
    end
    tail = head_all ? '0 : tail_red;
    if (cfg_i.max_transfer == 32'd0) begin
      chunk = 32'd0;
    end else if (cfg_i.max_transfer < 32'(ss)) begin
      chunk = 32'(ss);
    end else begin
      chunk = cfg_i.max_transfer - 32'(mt_mod);
    end
    k = PIECE_W'(MAX_PIECES) - PIECE_W'(has_head) - PIECE_W'(tail != '0);
  end

  // Direct pieces exceed the budget when the span is longer than k chunks
  assign too_many = (chunk_q != 32'd0) && (PROD_W'(direct_len_q) > prod_q);
  assign status   = invalid_q ? STATUS_INVALID :
                    (too_many ? STATUS_TOO_MANY : STATUS_OK);

  // Sequence the front
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (req_valid_i) begin
          state_d = F_CHECK;
        end
      end
      F_CHECK: begin
        state_d = bad ? F_PUSH : F_DIV;
      end
      F_DIV: begin
        if (!rem_busy) begin
          state_d = F_PLAN;
        end
      end
      F_PLAN: begin
        state_d = F_SIZE;
      end
      F_SIZE: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request and its sizes
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (req_valid_i) begin
          req_q <= req_i;
        end
      end
      F_CHECK: begin
        invalid_q <= bad;
      end
      F_PLAN: begin
        within_q   <= sec_off;
        has_head_q <= has_head;
        head_cnt_q <= head_cnt;
        tail_q     <= tail;
        head_off_q <= req_q.start_offset - 64'(sec_off);
        chunk_q    <= chunk;
        k_q        <= k;
      end
      F_SIZE: begin
        direct_len_q <= req_q.byte_length - 32'(head_cnt_q) - 32'(tail_q);
        mid_off_q    <= req_q.start_offset + 64'(head_cnt_q);
        prod_q       <= PROD_W'(k_q) * PROD_W'(chunk_q);
      end
      default: begin
      end
    endcase
  end

  assign req_ready_o = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;

  always_comb begin
    plan_o              = '0;
    plan_o.status       = status;
    plan_o.mode         = req_q.mode;
    plan_o.sector_bytes = ss;
    plan_o.sec_off      = within_q;
    plan_o.has_head     = has_head_q;
    plan_o.head_cnt     = head_cnt_q;
    plan_o.head_off     = head_off_q;
    plan_o.mid_off      = mid_off_q;
    plan_o.direct_len   = direct_len_q;
    plan_o.chunk        = chunk_q;
    plan_o.tail_cnt     = tail_q;
  end

endmodule

/* rtl/sats_fifo.sv */
// ----------------------------------------------------------------------------
// sats_fifo: plan queue
// Short first-in first-out queue of classified requests between the front
// and the back.
// ----------------------------------------------------------------------------
module sats_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sats_pkg::plan_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sats_pkg::plan_t rdata_o
);
  import sats_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  plan_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push;
  logic              do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

endmodule

/* rtl/sats_back.sv */
// ----------------------------------------------------------------------------
// sats_back: command issue
// Takes one plan at a time and walks it, issuing the head bounce command,
// the capped direct commands and the tail bounce command, or one error result,
// one per cycle while cmd_o is not stalled, through an output register.
// ----------------------------------------------------------------------------
module sats_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sats_pkg::plan_t plan_i,
  output logic            pop_o,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output sats_pkg::cmd_t  cmd_o
);
  import sats_pkg::*;

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_HEAD   = 3'd1;
  localparam logic [2:0] B_DIRECT = 3'd2;
  localparam logic [2:0] B_TAIL   = 3'd3;
  localparam logic [2:0] B_ERROR  = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic       out_valid_q;

  logic [1:0]      status_q;
  logic            mode_q;
  logic [SS_W-1:0] ss_q;
  logic [SS_W-1:0] within_q;
  logic [SS_W-1:0] head_cnt_q;
  logic [63:0]     head_off_q;
  logic [63:0]     off_q, off_d;
  logic [31:0]     dlen_q, dlen_d;
  logic [31:0]     chunk_q;
  logic [SS_W-1:0] tail_q;
  logic [31:0]     done_q, done_d;
  cmd_t            cmd_q, cmd_d;

  logic        load;
  logic        emit;
  logic [31:0] cnt;
  logic [2:0]  start_phase;

  assign load  = !out_valid_q || cmd_ready_i;
  assign emit  = (phase_q != B_IDLE) && load;
  assign pop_o = (phase_q == B_IDLE) && !empty_i;

  // Direct command size: the rest of the span or one chunk
  assign cnt = ((chunk_q == 32'd0) || (dlen_q <= chunk_q)) ? dlen_q : chunk_q;

  always_comb begin
    if (plan_i.status != STATUS_OK) begin
      start_phase = B_ERROR;
    end else if (plan_i.has_head) begin
      start_phase = B_HEAD;
    end else begin
      start_phase = B_DIRECT;
    end
  end

  // Build the next command and advance the walk
  always_comb begin
    cmd_d   = '0;
    phase_d = phase_q;
    off_d   = off_q;
    dlen_d  = dlen_q;
    done_d  = done_q;
    case (phase_q)
      B_IDLE: begin
        if (pop_o) begin
          phase_d = start_phase;
        end
      end
      B_HEAD: begin
        cmd_d.status        = STATUS_OK;
        cmd_d.via_bounce    = 1'b1;
        cmd_d.is_write      = mode_q;
        cmd_d.device_offset = head_off_q;
        cmd_d.device_bytes  = 32'(ss_q);
        cmd_d.bounce_start  = within_q[11:0];
        cmd_d.copy_bytes    = 32'(head_cnt_q);
        cmd_d.last          = (dlen_q == 32'd0) && (tail_q == '0);
        done_d              = 32'(head_cnt_q);
        if (dlen_q != 32'd0) begin
          phase_d = B_DIRECT;
        end else if (tail_q != '0) begin
          phase_d = B_TAIL;
        end else begin
          phase_d = B_IDLE;
        end
      end
      B_DIRECT: begin
        cmd_d.status        = STATUS_OK;
        cmd_d.is_write      = mode_q;
        cmd_d.device_offset = off_q;
        cmd_d.device_bytes  = cnt;
        cmd_d.buffer_offset = done_q;
        cmd_d.copy_bytes    = cnt;
        cmd_d.last          = (dlen_q == cnt) && (tail_q == '0);
        off_d               = off_q + 64'(cnt);
        done_d              = done_q + cnt;
        dlen_d              = dlen_q - cnt;
        if (dlen_q != cnt) begin
          phase_d = B_DIRECT;
        end else if (tail_q != '0) begin
          phase_d = B_TAIL;
        end else begin
          phase_d = B_IDLE;
        end
      end
      B_TAIL: begin
        cmd_d.status        = STATUS_OK;
        cmd_d.via_bounce    = 1'b1;
        cmd_d.is_write      = mode_q;
        cmd_d.device_offset = off_q;
        cmd_d.device_bytes  = 32'(ss_q);
        cmd_d.buffer_offset = done_q;
        cmd_d.copy_bytes    = 32'(tail_q);
        cmd_d.last          = 1'b1;
        phase_d             = B_IDLE;
      end
      B_ERROR: begin
        cmd_d.status = status_q;
        cmd_d.last   = 1'b1;
        phase_d      = B_IDLE;
      end
      default: begin
        phase_d = B_IDLE;
      end
    endcase
  end

  // Advance the walk and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o || emit) begin
        phase_q <= phase_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (cmd_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load a plan, then hold the command and the running position
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q   <= plan_i.status;
      mode_q     <= plan_i.mode;
      ss_q       <= plan_i.sector_bytes;
      within_q   <= plan_i.sec_off;
      head_cnt_q <= plan_i.head_cnt;
      head_off_q <= plan_i.head_off;
      off_q      <= plan_i.mid_off;
      dlen_q     <= plan_i.direct_len;
      chunk_q    <= plan_i.chunk;
      tail_q     <= plan_i.tail_cnt;
      done_q     <= 32'd0;
    end else if (emit) begin
      cmd_q  <= cmd_d;
      off_q  <= off_d;
      dlen_q <= dlen_d;
      done_q <= done_d;
    end
  end

  assign cmd_valid_o = out_valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* verif/tb_sector_aligned_transfer_splitter.sv */
// ----------------------------------------------------------------------------
// tb_sector_aligned_transfer_splitter: self-checking bench of the splitter
// Drives byte-range requests on req_i under several register settings and
// checks every command on cmd_o, field by field and in order, against a
// command plan computed here for each accepted request. Both channels idle
// at random, and the command side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_sector_aligned_transfer_splitter;
  import sats_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam int unsigned IDLE_PCT       = 6;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned STALL_LIMIT    = 6000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned MAX_REPORTS    = 10;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [63:0]          cfg_data_i;

  sats_stream_if #(.payload_t(req_t)) req_if ();
  sats_stream_if #(.payload_t(cmd_t)) cmd_if ();

  sector_aligned_transfer_splitter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .cmd_o      (cmd_if)
  );

  // Register copies for the command planner
  logic [SS_W-1:0] sector_sz;
  logic [31:0]     xfer_cap;
  logic [63:0]     cap_bytes;

  req_t        req_backlog[$];
  cmd_t        expected_cmds[$];
  int unsigned errors;
  int unsigned cyc;
  int unsigned quiet_cycles;
  bit          hold_armed;
  bit          hold_done;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Random breaks for both sides, save a stretch of the run in which neither side takes one
  function automatic bit take_break();
    if (cyc >= 3000 && cyc < 6000) begin
      return 1'b0;
    end
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic string fmt_cmd(input cmd_t c);
    return {$sformatf("st=%0d bnc=%0b wr=%0b doff=%h dbytes=%h ",
                      c.status, c.via_bounce, c.is_write, c.device_offset,
                      c.device_bytes),
            $sformatf("boff=%h bstart=%h copy=%h last=%0b",
                      c.buffer_offset, c.bounce_start, c.copy_bytes, c.last)};
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    case (idx)
      CFG_SECTOR_BYTES: sector_sz = data[SS_W-1:0];
      CFG_MAX_TRANSFER: xfer_cap  = data[31:0];
      CFG_CAPACITY:     cap_bytes = data;
      default: ;
    endcase
  endfunction

  // Split one request into its device commands and queue them
  function automatic void plan_commands(input req_t rq);
    cmd_t        pieces[$];
    cmd_t        c;
    logic [64:0] span_end;
    logic [63:0] ss;
    logic [63:0] pos;
    logic [63:0] sec_off;
    logic [63:0] cnt;
    logic [63:0] remaining;
    logic [63:0] done;
    int          n;
    ss = 64'(sector_sz);
    span_end = {1'b0, rq.start_offset} + 65'(rq.byte_length);
    c = '0;
    c.last = 1'b1;
    if (rq.byte_length == 32'd0 || ss == 64'd0 || ss > 64'(BOUNCE_BYTES) ||
        span_end[64] || span_end[63:0] > cap_bytes) begin
      c.status = STATUS_INVALID;
      expected_cmds.push_back(c);
      return;
    end
    pos = rq.start_offset;
    remaining = 64'(rq.byte_length);
    done = '0;
    n = 0;
    while (remaining != 64'd0) begin
      sec_off = pos % ss;
      if (n >= MAX_PIECES) begin
        c = '0;
        c.status = STATUS_TOO_MANY;
        c.last = 1'b1;
        expected_cmds.push_back(c);
        return;
      end
      c = '0;
      c.status = STATUS_OK;
      c.is_write = rq.mode;
      c.buffer_offset = done[31:0];
      if (sec_off == 64'd0 && remaining >= ss) begin
        // Direct span: capped, trimmed to whole sectors, never below one
        cnt = remaining;
        if (xfer_cap != 32'd0 && cnt > 64'(xfer_cap)) begin
          cnt = 64'(xfer_cap);
        end
        cnt = cnt - cnt % ss;
        if (cnt == 64'd0) begin
          cnt = ss;
        end
        c.device_offset = pos;
        c.device_bytes = cnt[31:0];
      end else begin
        // Partial sector through the bounce buffer
        cnt = ss - sec_off;
        if (cnt > remaining) begin
          cnt = remaining;
        end
        c.via_bounce = 1'b1;
        c.device_offset = pos - sec_off;
        c.device_bytes = ss[31:0];
        c.bounce_start = sec_off[11:0];
      end
      c.copy_bytes = cnt[31:0];
      c.last = (cnt == remaining);
      pieces.push_back(c);
      pos = pos + cnt;
      done = done + cnt;
      remaining = remaining - cnt;
      n++;
    end
    foreach (pieces[i]) begin
      expected_cmds.push_back(pieces[i]);
    end
  endfunction

  function automatic void check_cmd(input cmd_t got);
    cmd_t want;
    bit   bad;
    if (expected_cmds.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("unexpected command: %s", fmt_cmd(got));
      end
      return;
    end
    want = expected_cmds.pop_front();
    bad = (got.status !== want.status) || (got.via_bounce !== want.via_bounce) ||
          (got.is_write !== want.is_write) || (got.device_offset !== want.device_offset) ||
          (got.device_bytes !== want.device_bytes) ||
          (got.buffer_offset !== want.buffer_offset) ||
          (got.bounce_start !== want.bounce_start) || (got.copy_bytes !== want.copy_bytes) ||
          (got.last !== want.last);
    if (bad) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("command mismatch: expected %s", fmt_cmd(want));
        $display("                  actual   %s", fmt_cmd(got));
      end
    end
  endfunction

  // Request driver: plan each accepted transfer, offer the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        plan_commands(req_if.data);
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && !take_break()) begin
          req_if.valid <= 1'b1;
          req_if.data  <= req_backlog.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Command monitor: check each transfer, pace ready, hold off once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        check_cmd(cmd_if.data);
      end
      if (hold_armed && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        cmd_if.ready <= 1'b0;
      end else begin
        cmd_if.ready <= !take_break();
      end
    end
  end

  // Watchdog: end the run when no transfer moves for too long
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("tb_sector_aligned_transfer_splitter: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    apply_cfg(idx, data);
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input logic [63:0] ss, input logic [63:0] mt, input logic [63:0] cap);
    cfg_write(CFG_SECTOR_BYTES, ss);
    cfg_write(CFG_MAX_TRANSFER, mt);
    cfg_write(CFG_CAPACITY, cap);
    cfg_close();
  endtask

  task automatic add_req(input logic mode, input logic [63:0] off, input logic [31:0] len);
    req_t rq;
    rq.mode = mode;
    rq.start_offset = off;
    rq.byte_length = len;
    req_backlog.push_back(rq);
  endtask

  // Wait until every request is taken and every command has come back
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (req_backlog.size() != 0 || req_if.valid || expected_cmds.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] eff_sector();
    if (sector_sz == '0 || sector_sz > SS_W'(BOUNCE_BYTES)) begin
      return 64'(BOUNCE_BYTES);
    end
    return 64'(sector_sz);
  endfunction

  // Random register setting, mostly valid; upper data bits are noise
  task automatic rand_regs();
    int unsigned     p;
    logic [SS_W-1:0] ss;
    logic [63:0]     mt;
    logic [63:0]     cap;
    p = $urandom_range(19);
    if (p == 0) ss = '0;
    else if (p == 1) ss = SS_W'($urandom_range(BOUNCE_BYTES + 1, 8191));
    else if (p < 6) ss = SS_W'(512);
    else if (p < 9) ss = SS_W'(BOUNCE_BYTES);
    else if (p < 11) ss = SS_W'(1);
    else ss = SS_W'($urandom_range(1, BOUNCE_BYTES));
    cfg_write(CFG_SECTOR_BYTES, (rand64() << SS_W) | 64'(ss));
    p = $urandom_range(9);
    if (p < 3) mt = 64'd0;
    else if (p < 6) mt = eff_sector() * 64'($urandom_range(1, 16));
    else if (p == 6) mt = 64'($urandom_range(1, 32'(eff_sector())));
    else if (p == 7) mt = 64'hFFFF_FFFF;
    else mt = 64'($urandom);
    cfg_write(CFG_MAX_TRANSFER, {$urandom, mt[31:0]});
    p = $urandom_range(5);
    if (p < 3) cap = '1;
    else if (p == 3) cap = rand64();
    else cap = 64'($urandom_range(1, 1 << 24));
    cfg_write(CFG_CAPACITY, cap);
    cfg_close();
  endtask

  // Random request: mostly in range, some noise and bad ranges
  function automatic req_t make_req();
    req_t        rq;
    logic [63:0] ss;
    logic [63:0] room;
    int unsigned pick;
    ss = eff_sector();
    pick = $urandom_range(99);
    rq.mode = 1'($urandom_range(1));
    rq.start_offset = rand64();
    rq.byte_length = $urandom;
    if (pick < 4) begin
      rq.byte_length = '0;
    end else if (pick >= 10) begin
      if (pick >= 20) begin
        rq.byte_length = $urandom_range(1, 32'(8 * ss));
      end else if (rq.byte_length == '0) begin
        rq.byte_length = 32'd1;
      end
      if (cap_bytes >= 64'(rq.byte_length)) begin
        room = cap_bytes - 64'(rq.byte_length);
        if (room != '1) begin
          rq.start_offset = rq.start_offset % (room + 64'd1);
        end
        if ($urandom_range(2) == 0) begin
          rq.start_offset = rq.start_offset - rq.start_offset % ss;
        end
        if ($urandom_range(9) == 0) begin
          rq.start_offset = room;
        end
      end
    end
    return rq;
  endfunction

  task automatic rand_batch(input int unsigned count);
    repeat (count) req_backlog.push_back(make_req());
  endtask

  initial begin
    errors = 0;
    cyc = 0;
    quiet_cycles = 0;
    hold_armed = 1'b0;
    hold_done = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cmd_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SECTOR_BYTES;
    cfg_data_i = '0;
    sector_sz = SS_W'(512);
    xfer_cap = '0;
    cap_bytes = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero capacity rejects everything
    add_req(MODE_READ, 64'd0, 32'd512);
    add_req(MODE_WRITE, 64'd0, 32'd0);
    wait_idle();

    // 512-byte sectors with junk in the upper data bits, no cap, full capacity
    set_regs(64'hFFFF_FFFF_FFFF_E200, 64'd0, '1);
    add_req(MODE_WRITE, 64'd0, 32'd512);
    add_req(MODE_READ, 64'd100, 32'd2000);
    add_req(MODE_WRITE, 64'd10, 32'd20);
    add_req(MODE_READ, 64'd0, 32'hFFFF_FFFF);
    add_req(MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
    add_req(MODE_READ, 64'hFFFF_FFFF_FFFF_FFFE, 32'd1);
    add_req(MODE_WRITE, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF);
    add_req(MODE_READ, 64'd4096, 32'd0);
    wait_idle();

    // Largest sector, one-sector cap, 1 MiB capacity: piece limit and bounds
    set_regs(64'd4096, 64'hDEAD_BEEF_0000_1000, 64'd1 << 20);
    add_req(MODE_READ, 64'd0, 32'(64 * 4096));
    add_req(MODE_WRITE, 64'd0, 32'(65 * 4096));
    add_req(MODE_WRITE, 64'd100, 32'(63 * 4096));
    add_req(MODE_READ, (64'd1 << 20) - 64'd10, 32'd10);
    add_req(MODE_READ, (64'd1 << 20) - 64'd10, 32'd11);
    add_req(MODE_WRITE, 64'd5000, 32'd4096);
    wait_idle();

    // One-byte sectors: everything direct
    set_regs(64'd1, 64'd100, '1);
    add_req(MODE_WRITE, 64'd12345, 32'd1000);
    add_req(MODE_READ, 64'd7, 32'd1);
    wait_idle();

    // Cap below one sector still moves whole sectors
    set_regs(64'd512, 64'd100, '1);
    add_req(MODE_READ, 64'd1024, 32'd2048);
    add_req(MODE_WRITE, 64'd3, 32'd1500);
    wait_idle();

    // Zero sector size, then one above the bounce buffer
    set_regs(64'd0, 64'd0, '1);
    add_req(MODE_READ, 64'd0, 32'd1);
    wait_idle();
    set_regs(64'(BOUNCE_BYTES + 1), 64'd0, '1);
    add_req(MODE_WRITE, 64'd0, 32'd1);
    wait_idle();

    // Non-power-of-two sector size, largest cap; the spare index must change nothing
    cfg_write(CFG_SECTOR_BYTES, 64'd520);
    cfg_write(CFG_MAX_TRANSFER, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(CFG_CAPACITY, '1);
    cfg_write(CFG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_close();
    add_req(MODE_WRITE, 64'd1000, 32'hFFFF_FFFF);
    add_req(MODE_READ, 64'd519, 32'd2);
    wait_idle();

    // Random part; the first batch runs against a long command hold-off
    set_regs(64'd512, 64'd0, '1);
    rand_batch(30);
    hold_armed = 1'b1;
    wait_idle();
    repeat (4) begin
      rand_regs();
      rand_batch(14);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("tb_sector_aligned_transfer_splitter: done, clean");
    end else begin
      $display("tb_sector_aligned_transfer_splitter: done, errors");
    end
    $finish;
  end

endmodule
